[src/slab_object_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the slab object allocator
// Each macro expands to a labeled concurrent assertion or to nothing.
// ----------------------------------------------------------------------------
`ifndef SLAB_OBJECT_ALLOCATOR_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SOA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SOA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/soa_pkg.sv]
// ----------------------------------------------------------------------------
// soa_pkg
// Types and constants shared by the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;
	localparam int POOL_PAGES = 16;
	localparam int MAX_SLOTS  = 256;
	localparam int PAGE_BYTES = 4096;
	localparam int PG_W   = $clog2(POOL_PAGES);
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int PCNT_W = $clog2(POOL_PAGES + 1);
	localparam int OFF_W  = $clog2(PAGE_BYTES);

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_SHRINK = 2'd2;

	localparam logic [1:0] TAG_NONE = 2'd0;
	localparam logic [1:0] TAG_FREE = 2'd1;
	localparam logic [1:0] TAG_PART = 2'd2;
	localparam logic [1:0] TAG_FULL = 2'd3;

	localparam logic [1:0] REG_OBJECT_SIZE = 2'd0;
	localparam logic [1:0] REG_OBJECTS_PER_PAGE = 2'd1;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] object_address;
	} request_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] granted_address;
		logic [4:0]  released_count;
		logic [4:0]  pages_free;
	} result_t;
endpackage

[src/slab_object_allocator.sv]
// ----------------------------------------------------------------------------
// slab_object_allocator
// One object cache over a page pool, slot links kept in a synchronous RAM.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// request  in   start & !busy           request_t
// result   out  done strobe, one cycle  result_t
// config   in   cfg_we                  cfg_index, cfg_data
//
// Alloc steps through pick, read, wait, update and done states, with a grow
// step after pick when it takes a new slab (one slot link a cycle, up to 256).
// Free runs a check, a divide (one quotient bit a cycle), the update and the
// done state. Shrink releases free slabs, then ends. Rejected items end early.
// busy stays high from accept until the done cycle; results cannot be stalled.
// Reset clears list tags and heads; slab RAM content is undefined until written.
`include "slab_object_allocator_macros.svh"
module slab_object_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  soa_pkg::request_t   request,
	output logic                done,
	output soa_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data
);
	import soa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC, S_GROW, S_ARD, S_AWAIT, S_AFIN,
		S_FCHK, S_DIV, S_FDO, S_SHRINK, S_DONE
	} state_t;

	state_t state_q;
	logic [11:0] object_size_q;
	logic [8:0]  objects_per_page_q;
	logic [1:0]  tag_q [POOL_PAGES];
	logic [PG_W-1:0] next_q [POOL_PAGES];
	logic [PG_W-1:0] prev_q [POOL_PAGES];
	logic        nnil_q [POOL_PAGES];
	logic        pnil_q [POOL_PAGES];
	logic [PG_W-1:0] head_q [3];
	logic        hval_q [3];
	logic [CNT_W-1:0] used_q [POOL_PAGES];
	logic [SLOT_W-1:0] fhead_q [POOL_PAGES];
	logic        fend_q [POOL_PAGES];
	logic [PCNT_W-1:0] unowned_q;
	logic [PCNT_W-1:0] rel_q;

	// slot link RAM: {end flag, next slot}
	logic [SLOT_W:0] link_mem [POOL_PAGES*MAX_SLOTS];
	logic [SLOT_W:0] link_rd_q;
	logic            lwe;
	logic [PG_W+SLOT_W-1:0] lwa, lra;
	logic [SLOT_W:0] lwd;

	logic [PG_W-1:0] pg_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] i_q;
	logic [15:0] res_addr_q;
	logic        ok_q;
	logic [OFF_W:0] rem_q;
	logic [OFF_W-1:0] quo_q;
	logic [4:0]  div_i_q;
	logic [15:0] addr_q;

	logic [11:0] sz;
	logic [CNT_W-1:0] n;
	logic [OFF_W:0] n2;
	logic [OFF_W:0] trial;
	logic [PG_W:0] lowfree;
	logic [PG_W-1:0] shrink_pg;

	always_comb begin
		sz = (object_size_q == 12'd0) ? 12'd1 : object_size_q;
		if (objects_per_page_q == 9'd0) n = CNT_W'(1);
		else if (32'(objects_per_page_q) > MAX_SLOTS) n = CNT_W'(MAX_SLOTS);
		else n = CNT_W'(objects_per_page_q);
		n2 = (OFF_W+1)'({n, 1'b0});
		trial = {rem_q[OFF_W-1:0], addr_q[div_i_q[3:0]]};
		lowfree = (PG_W+1)'(POOL_PAGES);
		for (int p = POOL_PAGES-1; p >= 0; p--)
			if (tag_q[p] == TAG_NONE) lowfree = (PG_W+1)'(p);
		shrink_pg = head_q[0];
	end

	always_ff @(posedge clk) begin
		if (lwe) link_mem[lwa] <= lwd;
		link_rd_q <= link_mem[lra];
	end

	always_comb begin
		lwe = 1'b0;
		lwa = {pg_q, i_q[SLOT_W-1:0]};
		lwd = '0;
		lra = {pg_q, slot_q};
		if (state_q == S_GROW) begin
			lwe = 1'b1;
			lwd = (i_q + CNT_W'(1) == n) ? {1'b1, {SLOT_W{1'b0}}}
				: {1'b0, SLOT_W'(i_q + CNT_W'(1))};
		end else if (state_q == S_FDO) begin
			lwe = 1'b1;
			lwa = {pg_q, slot_q};
			lwd = {fend_q[pg_q], fhead_q[pg_q]};
		end
	end

	// list relink helper outputs computed inline in the clocked block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			object_size_q <= 12'd16;
			objects_per_page_q <= 9'd227;
			for (int p = 0; p < POOL_PAGES; p++) tag_q[p] <= TAG_NONE;
			for (int k = 0; k < 3; k++) hval_q[k] <= 1'b0;
			unowned_q <= PCNT_W'(POOL_PAGES);
			done <= 1'b0;
			ok_q <= 1'b0;
			rel_q <= '0;
			res_addr_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_OBJECT_SIZE) object_size_q <= cfg_data;
				else if (cfg_index == REG_OBJECTS_PER_PAGE)
					objects_per_page_q <= cfg_data[8:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ok_q <= 1'b0;
						rel_q <= '0;
						res_addr_q <= '0;
						addr_q <= request.object_address;
						i_q <= '0;
						case (request.action)
							ACT_ALLOC: state_q <= S_ALLOC;
							ACT_FREE: begin
								rem_q <= '0;
								quo_q <= '0;
								div_i_q <= 5'(OFF_W - 1);
								state_q <= S_FCHK;
							end
							ACT_SHRINK: begin
								ok_q <= 1'b1;
								state_q <= S_SHRINK;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ALLOC: begin
					if (hval_q[1]) begin
						pg_q <= head_q[1];
						state_q <= S_ARD;
					end else if (hval_q[0]) begin
						pg_q <= head_q[0];
						state_q <= S_ARD;
					end else if (lowfree[PG_W] == 1'b0) begin
						pg_q <= lowfree[PG_W-1:0];
						state_q <= S_GROW;
					end else state_q <= S_DONE;
				end
				S_GROW: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q + CNT_W'(1) == n) begin
						used_q[pg_q] <= '0;
						fhead_q[pg_q] <= '0;
						fend_q[pg_q] <= 1'b0;
						unowned_q <= unowned_q - PCNT_W'(1);
						next_q[pg_q] <= head_q[0];
						nnil_q[pg_q] <= !hval_q[0];
						pnil_q[pg_q] <= 1'b1;
						if (hval_q[0]) begin
							prev_q[head_q[0]] <= pg_q;
							pnil_q[head_q[0]] <= 1'b0;
						end
						head_q[0] <= pg_q;
						hval_q[0] <= 1'b1;
						tag_q[pg_q] <= TAG_FREE;
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					if (fend_q[pg_q]) state_q <= S_DONE;
					else begin
						slot_q <= fhead_q[pg_q];
						state_q <= S_AWAIT;
					end
				end
				S_AWAIT: state_q <= S_AFIN;
				S_AFIN, S_FDO: begin : relink
					logic [CNT_W-1:0] nu;
					logic [1:0] nt;
					logic [1:0] ot;
					ot = tag_q[pg_q];
					if (state_q == S_AFIN) begin
						nu = used_q[pg_q] + CNT_W'(1);
						nt = (nu == n) ? TAG_FULL : TAG_PART;
						fhead_q[pg_q] <= link_rd_q[SLOT_W-1:0];
						fend_q[pg_q] <= link_rd_q[SLOT_W];
						res_addr_q <= 16'(32'(pg_q) * PAGE_BYTES + 32'(n2)
							+ 32'(slot_q) * 32'(sz));
					end else begin
						nu = used_q[pg_q] - CNT_W'(1);
						nt = (nu == '0) ? TAG_FREE : TAG_PART;
						fhead_q[pg_q] <= slot_q;
						fend_q[pg_q] <= 1'b0;
					end
					used_q[pg_q] <= nu;
					ok_q <= 1'b1;
					// unlink, then push at head of the new list
					if (pnil_q[pg_q]) begin
						if (nnil_q[pg_q]) hval_q[ot - 2'd1] <= 1'b0;
						else head_q[ot - 2'd1] <= next_q[pg_q];
					end else begin
						next_q[prev_q[pg_q]] <= next_q[pg_q];
						nnil_q[prev_q[pg_q]] <= nnil_q[pg_q];
					end
					if (!nnil_q[pg_q]) begin
						prev_q[next_q[pg_q]] <= prev_q[pg_q];
						pnil_q[next_q[pg_q]] <= pnil_q[pg_q];
					end
					begin : push
						logic hv;
						logic [PG_W-1:0] h;
						hv = hval_q[nt - 2'd1];
						h = head_q[nt - 2'd1];
						if (ot == nt) begin
							if (pnil_q[pg_q]) begin
								hv = !nnil_q[pg_q];
								h = next_q[pg_q];
							end
						end
						if (hv && h == pg_q) hv = 1'b0;
						next_q[pg_q] <= h;
						nnil_q[pg_q] <= !hv;
						pnil_q[pg_q] <= 1'b1;
						if (hv) begin
							prev_q[h] <= pg_q;
							pnil_q[h] <= 1'b0;
						end
						head_q[nt - 2'd1] <= pg_q;
						hval_q[nt - 2'd1] <= 1'b1;
					end
					tag_q[pg_q] <= nt;
					state_q <= S_DONE;
				end
				S_FCHK: begin
					pg_q <= addr_q[OFF_W+PG_W-1:OFF_W];
					if ((32'(addr_q) >> OFF_W) >= POOL_PAGES
						|| tag_q[addr_q[OFF_W+PG_W-1:OFF_W]] == TAG_NONE
						|| (OFF_W+1)'(addr_q[OFF_W-1:0]) < n2)
						state_q <= S_DONE;
					else begin
						addr_q <= 16'((OFF_W+1)'(addr_q[OFF_W-1:0]) - n2);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (trial >= (OFF_W+1)'(sz)) begin
						rem_q <= trial - (OFF_W+1)'(sz);
						quo_q <= {quo_q[OFF_W-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[OFF_W-2:0], 1'b0};
					end
					div_i_q <= div_i_q - 5'd1;
					if (div_i_q == 5'd0) state_q <= S_FDO;
				end
				S_SHRINK: begin
					if (hval_q[0] && rel_q < PCNT_W'(POOL_PAGES)) begin
						tag_q[shrink_pg] <= TAG_NONE;
						unowned_q <= unowned_q + PCNT_W'(1);
						rel_q <= rel_q + PCNT_W'(1);
						head_q[0] <= next_q[shrink_pg];
						hval_q[0] <= !nnil_q[shrink_pg];
					end else begin
						hval_q[0] <= 1'b0;
						state_q <= S_DONE;
					end
				end
				default: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
			// free validity checked on the last divide step
			if (state_q == S_DIV && div_i_q == 5'd0) begin
				if ((trial >= (OFF_W+1)'(sz) ? trial - (OFF_W+1)'(sz) : trial) != '0
					|| (CNT_W+OFF_W)'({quo_q[OFF_W-2:0],
						trial >= (OFF_W+1)'(sz)}) >= (CNT_W+OFF_W)'(n)
					|| used_q[pg_q] == '0)
					state_q <= S_DONE;
				slot_q <= SLOT_W'({quo_q[OFF_W-2:0], trial >= (OFF_W+1)'(sz)});
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign result.ok = ok_q;
	assign result.granted_address = ok_q ? res_addr_q : 16'd0;
	assign result.released_count = 5'(rel_q);
	assign result.pages_free = 5'(unowned_q);

	`SOA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`SOA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`SOA_ASSERT_IMP(a_pool_bound, clk, arst_n, 1'b1, unowned_q <= PCNT_W'(POOL_PAGES))
	`SOA_ASSERT_IMP(a_rel_ok, clk, arst_n, done && rel_q != '0, ok_q)
endmodule
